[rtl/ipv4_route_prefix_lookup_macros.svh]
// Assertion macros used by the route prefix lookup RTL.
`ifndef IPV4_ROUTE_PREFIX_LOOKUP_MACROS_SVH
`define IPV4_ROUTE_PREFIX_LOOKUP_MACROS_SVH

`ifndef SYNTHESIS

// Checked property that is ignored while reset is asserted.
`define IPRPL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("route prefix lookup: assertion failed");

// Checked property that also holds during reset.
`define IPRPL_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("route prefix lookup: assertion failed");

`else

`define IPRPL_ASSERT(lbl, clk, rst_n, prop)
`define IPRPL_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[rtl/iprpl_pkg.sv]
// Package with the types, constants and helpers of the route prefix lookup.
`default_nettype none

package iprpl_pkg;

  // Route table depth and derived widths.
  localparam int unsigned ENTRIES = 16;
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Field widths.
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned STAT_W = 2;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

  // Command codes.
  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOROUTE = 2'd3
  } status_e;

  // One stored route.
  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] hop;
  } route_t;

  // Mask that keeps the top len bits of an address.
  function automatic logic [ADDR_W-1:0] top_mask(logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] mask;
    if (len == '0) begin
      mask = '0;
    end else if (len >= MAX_LEN) begin
      mask = '1;
    end else begin
      mask = {ADDR_W{1'b1}} << (MAX_LEN - len);
    end
    return mask;
  endfunction

endpackage

`default_nettype wire

[rtl/iprpl_req_if.sv]
// Request channel: add or lookup commands into the route table.
`default_nettype none

interface iprpl_req_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [iprpl_pkg::ADDR_W-1:0]      ip_addr;
  logic [iprpl_pkg::LEN_W-1:0]       prefix_len;
  logic [iprpl_pkg::ADDR_W-1:0]      next_hop;

  modport source (output valid, cmd, ip_addr, prefix_len, next_hop, input ready);
  modport sink   (input valid, cmd, ip_addr, prefix_len, next_hop, output ready);
endinterface

`default_nettype wire

[rtl/iprpl_rsp_if.sv]
// Response channel: status and next hop out of the route table.
`default_nettype none

interface iprpl_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [iprpl_pkg::STAT_W-1:0]      status;
  logic [iprpl_pkg::ADDR_W-1:0]      found_next_hop;

  modport source (output valid, status, found_next_hop, input ready);
  modport sink   (input valid, status, found_next_hop, output ready);
endinterface

`default_nettype wire

[rtl/ipv4_route_prefix_lookup.sv]
// Top level of the IPv4 route table with longest prefix match lookup.
`default_nettype none
`include "ipv4_route_prefix_lookup_macros.svh"

// The table holds up to ENTRIES routes in a memory with one write port and one
// registered read port that a small sequencer scans one entry per cycle,
// comparing each against the request in one shared compare stage. An add checks
// every stored route for a duplicate and then appends unless the table is full;
// a lookup keeps the longest matching route, the first one stored winning a tie.
// A request runs from its transfer through the scan, in which every stored
// route is read through the memory read port and then compared, then through
// the finish state, where the response is loaded into the output register once
// that register is free, and back to idle for the next transfer. A finished
// response waits in the output register, so the next request is taken while
// it is still pending; a request that finishes while the previous response
// still waits holds the block until that response is taken.
module ipv4_route_prefix_lookup (
  input  wire              clk_i,
  input  wire              rst_ni,
  iprpl_req_if.sink        req_i,
  iprpl_rsp_if.source      rsp_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e                            state_q;
  logic [iprpl_pkg::CNT_W-1:0]       count_q;
  logic [iprpl_pkg::CNT_W-1:0]       scan_q;
  logic                              cmp_vld_q;
  logic                              cmd_q;
  logic [iprpl_pkg::ADDR_W-1:0]      addr_q;
  logic [iprpl_pkg::LEN_W-1:0]       len_q;
  logic [iprpl_pkg::ADDR_W-1:0]      hop_q;
  logic                              dup_q;
  logic                              found_q;
  logic [iprpl_pkg::LEN_W-1:0]       best_len_q;
  logic [iprpl_pkg::ADDR_W-1:0]      best_hop_q;
  logic                              rsp_vld_q;
  logic [iprpl_pkg::STAT_W-1:0]      rsp_status_q;
  logic [iprpl_pkg::ADDR_W-1:0]      rsp_hop_q;

  iprpl_pkg::route_t                 mem_q [iprpl_pkg::ENTRIES];
  iprpl_pkg::route_t                 rd_q;
  iprpl_pkg::route_t                 wr_data;

  logic                              accept;
  logic                              issue;
  logic                              load;
  logic                              wr_en;
  logic                              hit_add;
  logic                              hit_lkp;
  logic                              better;
  logic [iprpl_pkg::LEN_W-1:0]       len_sat;
  logic [iprpl_pkg::STAT_W-1:0]      status_d;
  logic [iprpl_pkg::ADDR_W-1:0]      hop_d;

  // Handshake and sequencer strobes.
  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign issue       = (state_q == S_SCAN) && (scan_q < count_q);
  assign load        = (state_q == S_FINISH) && (!rsp_vld_q || rsp_o.ready);

  // Lengths above the address width saturate before compare and store.
  assign len_sat = (req_i.prefix_len > iprpl_pkg::MAX_LEN) ? iprpl_pkg::MAX_LEN
                                                           : req_i.prefix_len;

  // Shared compare stage on the entry read in the previous cycle.
  assign hit_add = (rd_q.prefix == addr_q) && (rd_q.len == len_q);
  assign hit_lkp = (rd_q.prefix == (addr_q & iprpl_pkg::top_mask(rd_q.len)));
  assign better  = !found_q || (rd_q.len > best_len_q);

  // Final status and next hop once the scan is complete.
  always_comb begin
    status_d = iprpl_pkg::ST_OK;
    hop_d    = '0;
    if (cmd_q == iprpl_pkg::CMD_ADD) begin
      if (dup_q) begin
        status_d = iprpl_pkg::ST_DUP;
      end else if (count_q == iprpl_pkg::CNT_W'(iprpl_pkg::ENTRIES)) begin
        status_d = iprpl_pkg::ST_FULL;
      end
    end else begin
      if (found_q) begin
        hop_d = best_hop_q;
      end else begin
        status_d = iprpl_pkg::ST_NOROUTE;
      end
    end
  end

  assign wr_en = load && (cmd_q == iprpl_pkg::CMD_ADD) && (status_d == iprpl_pkg::ST_OK);

  assign wr_data.prefix = addr_q;
  assign wr_data.len    = len_q;
  assign wr_data.hop    = hop_q;

  // Route memory: one write port for appends, one registered read for the scan.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[iprpl_pkg::IDX_W-1:0]] <= wr_data;
    end
    if (issue) begin
      rd_q <= mem_q[scan_q[iprpl_pkg::IDX_W-1:0]];
    end
  end

  // Sequencer, scan accumulators and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      scan_q       <= '0;
      cmp_vld_q    <= 1'b0;
      cmd_q        <= iprpl_pkg::CMD_ADD;
      addr_q       <= '0;
      len_q        <= '0;
      hop_q        <= '0;
      dup_q        <= 1'b0;
      found_q      <= 1'b0;
      best_len_q   <= '0;
      best_hop_q   <= '0;
      rsp_vld_q    <= 1'b0;
      rsp_status_q <= '0;
      rsp_hop_q    <= '0;
    end else begin
      // The response register fills at the end of a request and empties on a transfer.
      if (load) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q      <= req_i.cmd;
            addr_q     <= req_i.ip_addr;
            len_q      <= len_sat;
            hop_q      <= req_i.next_hop;
            scan_q     <= '0;
            cmp_vld_q  <= 1'b0;
            dup_q      <= 1'b0;
            found_q    <= 1'b0;
            best_len_q <= '0;
            state_q    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Read the next entry while the previous one is compared.
          cmp_vld_q <= issue;
          if (issue) begin
            scan_q <= scan_q + iprpl_pkg::CNT_W'(1);
          end
          if (cmp_vld_q) begin
            if (cmd_q == iprpl_pkg::CMD_ADD) begin
              if (hit_add) begin
                dup_q <= 1'b1;
              end
            end else if (hit_lkp && better) begin
              found_q    <= 1'b1;
              best_len_q <= rd_q.len;
              best_hop_q <= rd_q.hop;
            end
          end
          if (!issue && !cmp_vld_q) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (load) begin
            rsp_status_q <= status_d;
            rsp_hop_q    <= hop_d;
            if (wr_en) begin
              count_q <= count_q + iprpl_pkg::CNT_W'(1);
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Response channel outputs.
  assign rsp_o.valid          = rsp_vld_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.found_next_hop = rsp_hop_q;

  // The route count never passes the table depth.
  `IPRPL_ASSERT(a_count_bound, clk_i, rst_ni,
    count_q <= iprpl_pkg::CNT_W'(iprpl_pkg::ENTRIES))

  // The scan pointer never runs past the stored routes.
  `IPRPL_ASSERT(a_scan_bound, clk_i, rst_ni, scan_q <= count_q)

  // A successful add grows the table by exactly one route.
  `IPRPL_ASSERT(a_add_grows, clk_i, rst_ni,
    wr_en |=> (count_q == $past(count_q) + iprpl_pkg::CNT_W'(1)))

  // An add response carries a zero next hop and never reports no route.
  `IPRPL_ASSERT(a_add_rsp, clk_i, rst_ni,
    (load && cmd_q == iprpl_pkg::CMD_ADD) |=>
      (rsp_hop_q == '0 && rsp_status_q != iprpl_pkg::ST_NOROUTE))

endmodule

`default_nettype wire

[bench/ipv4_route_prefix_lookup_tb.sv]
// Self-checking testbench for the IPv4 route table with longest prefix match lookup.
module ipv4_route_prefix_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any transfer before the run is declared hung. The longest
  // legal quiet stretch is the long response hold plus a full-table scan.
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned SEGMENTS    = 8;
  localparam int unsigned SEG_ITEMS   = 122;

  typedef logic [iprpl_pkg::ADDR_W-1:0] addr_t;
  typedef logic [iprpl_pkg::LEN_W-1:0]  len_t;

  typedef struct packed {
    iprpl_pkg::cmd_e cmd;
    addr_t           addr;
    len_t            len;
    addr_t           hop;
  } route_req_t;

  typedef struct packed {
    iprpl_pkg::status_e status;
    addr_t              hop;
  } route_rsp_t;

  typedef struct packed {
    route_req_t req;
    bit         typed;
    route_rsp_t rsp;
  } directed_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  iprpl_req_if req_if ();
  iprpl_rsp_if rsp_if ();

  ipv4_route_prefix_lookup dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the route table.
  addr_t       tbl_prefix [iprpl_pkg::ENTRIES];
  len_t        tbl_len    [iprpl_pkg::ENTRIES];
  addr_t       tbl_hop    [iprpl_pkg::ENTRIES];
  int unsigned tbl_count;

  route_rsp_t    awaited_rsp_q [$];
  directed_row_t directed_rows [$];

  int unsigned error_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req       = 1'b0;
  int unsigned quiet_cycles   = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Mask that keeps the top len bits; a shift by the full width leaves zero.
  function automatic addr_t keep_top_bits(input len_t len);
    return ~({iprpl_pkg::ADDR_W{1'b1}} >> len);
  endfunction

  // Applies one request to the shadow table and returns the response it causes.
  function automatic route_rsp_t apply_route_request(input route_req_t r);
    route_rsp_t rsp;
    len_t       len;
    len_t       best;
    bit         hit;
    rsp.status = iprpl_pkg::ST_OK;
    rsp.hop    = '0;
    hit        = 1'b0;
    best       = '0;
    if (r.cmd == iprpl_pkg::CMD_ADD) begin
      len = (r.len > iprpl_pkg::MAX_LEN) ? iprpl_pkg::MAX_LEN : r.len;
      for (int i = 0; i < int'(tbl_count); i++) begin
        if (tbl_prefix[i] == r.addr && tbl_len[i] == len) hit = 1'b1;
      end
      if (hit) begin
        rsp.status = iprpl_pkg::ST_DUP;
      end else if (tbl_count >= iprpl_pkg::ENTRIES) begin
        rsp.status = iprpl_pkg::ST_FULL;
      end else begin
        tbl_prefix[tbl_count] = r.addr;
        tbl_len[tbl_count]    = len;
        tbl_hop[tbl_count]    = r.hop;
        tbl_count++;
      end
    end else begin
      // Strictly longer wins, so the first stored route keeps a tie.
      for (int i = 0; i < int'(tbl_count); i++) begin
        if (tbl_prefix[i] == (r.addr & keep_top_bits(tbl_len[i])) &&
            (!hit || tbl_len[i] > best)) begin
          hit     = 1'b1;
          best    = tbl_len[i];
          rsp.hop = tbl_hop[i];
        end
      end
      if (!hit) rsp.status = iprpl_pkg::ST_NOROUTE;
    end
    return rsp;
  endfunction

  // Random request: mostly lookups aimed at stored routes, adds nested under them.
  function automatic route_req_t pick_route_req(input int unsigned add_pct);
    route_req_t  r;
    int unsigned pick;
    int unsigned sel;
    len_t        len;
    addr_t       m;
    r.cmd  = iprpl_pkg::CMD_LOOKUP;
    r.addr = $urandom();
    r.len  = iprpl_pkg::LEN_W'($urandom_range(63));
    r.hop  = $urandom();
    pick   = $urandom_range(99);
    sel    = (tbl_count > 0) ? $urandom_range(tbl_count - 1) : 0;
    m      = keep_top_bits(tbl_len[sel]);
    len    = ($urandom_range(9) == 0) ? iprpl_pkg::LEN_W'($urandom_range(63, 33))
                                      : iprpl_pkg::LEN_W'($urandom_range(32));
    if ($urandom_range(99) < add_pct) begin
      r.cmd = iprpl_pkg::CMD_ADD;
      r.len = len;
      if (pick < 15 && tbl_count > 0) begin
        // Same route again, with an oversized length where it saturates to it.
        r.addr = tbl_prefix[sel];
        r.len  = (tbl_len[sel] == iprpl_pkg::MAX_LEN && pick < 5)
                 ? iprpl_pkg::LEN_W'($urandom_range(63, 33))
                 : tbl_len[sel];
      end else if (pick < 55 && tbl_count > 0) begin
        // A route inside a stored one, at least as long.
        r.len  = iprpl_pkg::LEN_W'($urandom_range(32, tbl_len[sel]));
        r.addr = ((tbl_prefix[sel] & m) | ($urandom() & ~m)) & keep_top_bits(r.len);
      end else if (pick < 85) begin
        r.addr = r.addr & keep_top_bits((len > iprpl_pkg::MAX_LEN) ? iprpl_pkg::MAX_LEN
                                                                    : len);
      end
      // Otherwise the prefix keeps stray bits below its length.
    end else if (pick < 75 && tbl_count > 0) begin
      r.addr = (tbl_prefix[sel] & m) | ($urandom() & ~m);
    end else if (pick < 85) begin
      r.addr = (pick < 80) ? '0 : '1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // Offers one request, waits for its transfer and records the awaited response.
  task automatic drive_request(input route_req_t r, input bit typed, input route_rsp_t want);
    route_rsp_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.cmd        <= r.cmd;
    req_if.ip_addr    <= r.addr;
    req_if.prefix_len <= r.len;
    req_if.next_hop   <= r.hop;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pred = apply_route_request(r);
    awaited_rsp_q.push_back(typed ? want : pred);
  endtask

  task automatic add_row(input iprpl_pkg::cmd_e c, input addr_t a, input len_t l,
                         input addr_t h, input bit typed, input iprpl_pkg::status_e s,
                         input addr_t eh);
    directed_row_t row;
    row.req.cmd    = c;
    row.req.addr   = a;
    row.req.len    = l;
    row.req.hop    = h;
    row.typed      = typed;
    row.rsp.status = s;
    row.rsp.hop    = eh;
    directed_rows.push_back(row);
  endtask

  // Compares one response transfer with the oldest awaited response.
  task automatic check_route_rsp();
    route_rsp_t want;
    if (awaited_rsp_q.size() == 0) begin
      report_mismatch("response with none awaited");
    end else begin
      want = awaited_rsp_q.pop_front();
      if (rsp_if.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", rsp_if.status, want.status));
      if (rsp_if.found_next_hop !== want.hop)
        report_mismatch($sformatf("next hop %h, expected %h", rsp_if.found_next_hop,
                                  want.hop));
    end
  endtask

  // Response side: checks transfers and stalls at random or for a long hold.
  initial begin : rsp_sink
    int unsigned hold_left;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) check_route_rsp();
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles without any transfer on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("ipv4_route_prefix_lookup test failed");
        $finish;
      end
    end
  end

  // Stimulus: directed rows first, then random segments with changing idling.
  initial begin : stimulus
    route_rsp_t  none;
    int unsigned add_pct;
    none.status       = iprpl_pkg::ST_OK;
    none.hop          = '0;
    tbl_count         = 0;
    req_if.valid      <= 1'b0;
    req_if.cmd        <= iprpl_pkg::CMD_ADD;
    req_if.ip_addr    <= '0;
    req_if.prefix_len <= '0;
    req_if.next_hop   <= '0;

    // Empty table, extremes, saturated length, stray low bits, default route.
    add_row(iprpl_pkg::CMD_LOOKUP, 32'h0000_0000, 6'd0,  32'h0,         1'b1,
            iprpl_pkg::ST_NOROUTE, 32'h0);
    add_row(iprpl_pkg::CMD_ADD,    32'h0A00_0000, 6'd8,  32'h0A00_00FE, 1'b1,
            iprpl_pkg::ST_OK,      32'h0);
    add_row(iprpl_pkg::CMD_ADD,    32'h0A00_0000, 6'd8,  32'h5555_5555, 1'b1,
            iprpl_pkg::ST_DUP,     32'h0);
    add_row(iprpl_pkg::CMD_LOOKUP, 32'h0A12_3456, 6'd63, 32'hFFFF_FFFF, 1'b0,
            iprpl_pkg::ST_OK,      32'h0);
    add_row(iprpl_pkg::CMD_LOOKUP, 32'h0B00_0000, 6'd0,  32'h0,         1'b0,
            iprpl_pkg::ST_OK,      32'h0);
    add_row(iprpl_pkg::CMD_ADD,    32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 1'b1,
            iprpl_pkg::ST_OK,      32'h0);
    add_row(iprpl_pkg::CMD_ADD,    32'hFFFF_FFFF, 6'd32, 32'h0,         1'b1,
            iprpl_pkg::ST_DUP,     32'h0);
    add_row(iprpl_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 6'd32, 32'h0,         1'b1,
            iprpl_pkg::ST_OK,      32'hFFFF_FFFF);
    add_row(iprpl_pkg::CMD_ADD,    32'h0A00_00FF, 6'd8,  32'h1111_1111, 1'b1,
            iprpl_pkg::ST_OK,      32'h0);
    add_row(iprpl_pkg::CMD_LOOKUP, 32'h0A00_00FF, 6'd8,  32'h0,         1'b0,
            iprpl_pkg::ST_OK,      32'h0);
    add_row(iprpl_pkg::CMD_ADD,    32'h0A00_00FF, 6'd8,  32'h2222_2222, 1'b1,
            iprpl_pkg::ST_DUP,     32'h0);
    add_row(iprpl_pkg::CMD_ADD,    32'h0000_0000, 6'd0,  32'h1234_5678, 1'b1,
            iprpl_pkg::ST_OK,      32'h0);
    add_row(iprpl_pkg::CMD_LOOKUP, 32'h55AA_55AA, 6'd17, 32'h0,         1'b0,
            iprpl_pkg::ST_OK,      32'h0);
    add_row(iprpl_pkg::CMD_ADD,    32'h0A12_0000, 6'd16, 32'h0A12_0001, 1'b1,
            iprpl_pkg::ST_OK,      32'h0);
    add_row(iprpl_pkg::CMD_LOOKUP, 32'h0A12_FFFF, 6'd0,  32'h0,         1'b0,
            iprpl_pkg::ST_OK,      32'h0);
    add_row(iprpl_pkg::CMD_ADD,    32'h8000_0000, 6'd1,  32'h8080_8080, 1'b1,
            iprpl_pkg::ST_OK,      32'h0);
    add_row(iprpl_pkg::CMD_LOOKUP, 32'h8000_0001, 6'd1,  32'h0,         1'b0,
            iprpl_pkg::ST_OK,      32'h0);
    add_row(iprpl_pkg::CMD_ADD,    32'hC0A8_0100, 6'd24, 32'h0,         1'b1,
            iprpl_pkg::ST_OK,      32'h0);
    add_row(iprpl_pkg::CMD_LOOKUP, 32'hC0A8_0105, 6'd24, 32'h0,         1'b0,
            iprpl_pkg::ST_OK,      32'h0);
    add_row(iprpl_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, 6'd42, 32'hAAAA_AAAA, 1'b0,
            iprpl_pkg::ST_OK,      32'h0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      drive_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

    for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 76;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 76;
        end
        default: begin
          send_idle_pct  = 29;
          recv_stall_pct = 29;
        end
      endcase
      // Long response hold while requests keep coming, so the input backs up.
      if (seg == 2) hold_req = 1'b1;
      // Sender pauses until the block has drained.
      if (seg == 5) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
        while (awaited_rsp_q.size() != 0) @(posedge clk_i);
      end
      // Adds stay rare early so the table fills slowly, then full is exercised.
      add_pct = (seg < 4) ? 4 : 30;
      repeat (SEG_ITEMS) drive_request(pick_route_req(add_pct), 1'b0, none);
    end

    req_if.valid <= 1'b0;
    recv_stall_pct = 0;
    while (awaited_rsp_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ipv4_route_prefix_lookup test passed");
    end else begin
      $display("ipv4_route_prefix_lookup test failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/iprpl_pkg.sv
rtl/iprpl_req_if.sv
rtl/iprpl_rsp_if.sv
rtl/ipv4_route_prefix_lookup.sv
bench/ipv4_route_prefix_lookup_tb.sv
